>>> hdl/mtes_pkg.sv
`default_nettype none

package mtes_pkg;

    // Operation codes of the input channel
    localparam logic [3:0] OP_NOTE_ON     = 4'd0;
    localparam logic [3:0] OP_NOTE_OFF    = 4'd1;
    localparam logic [3:0] OP_CTRL        = 4'd2;
    localparam logic [3:0] OP_PROG        = 4'd3;
    localparam logic [3:0] OP_BEND        = 4'd4;
    localparam logic [3:0] OP_TEMPO       = 4'd5;
    localparam logic [3:0] OP_TIMESIG     = 4'd6;
    localparam logic [3:0] OP_EOT         = 4'd7;
    localparam logic [3:0] OP_MASTVOL     = 4'd8;
    localparam logic [3:0] OP_GM_RESET    = 4'd9;
    localparam logic [3:0] OP_TRANSPOSE   = 4'd10;
    localparam logic [3:0] OP_TRACK_START = 4'd11;

    // Status and meta codes
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_PROG     = 8'hC0;
    localparam logic [7:0] ST_BEND     = 8'hE0;
    localparam logic [7:0] ST_META     = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_TSIG   = 8'h58;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_EOX      = 8'hF7;
    localparam logic [3:0] DRUM_CHAN   = 4'd9;

    // Longest event: 4 delta bytes plus 9 body bytes
    localparam int EVT_BYTES = 13;
    localparam int BODY_BYTES = 9;
    localparam int LEN_W = $clog2(EVT_BYTES + 1);

    typedef struct packed {
        logic [EVT_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
    } evt_t;

endpackage

`default_nettype wire

>>> hdl/mtes_encoder.sv
`default_nettype none

module mtes_encoder (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_fire,
    input  wire logic          cfg_data,
    input  wire logic          in_fire,
    input  wire logic [3:0]    operation,
    input  wire logic [27:0]   abs_time,
    input  wire logic [3:0]    channel,
    input  wire logic [7:0]    data_a,
    input  wire logic [7:0]    data_b,
    input  wire logic [7:0]    data_c,
    input  wire logic [13:0]   bend_amount,
    input  wire logic [23:0]   tempo_us,
    input  wire logic [7:0]    transpose_amount,
    output mtes_pkg::evt_t     evt
);
    import mtes_pkg::*;

    logic        monophonic_reg, monophonic_next;
    logic [27:0] prev_time_reg, prev_time_next;
    logic [7:0]  prev_key_reg, prev_key_next;
    logic [7:0]  transpose_reg, transpose_next;

    logic [27:0] delta;
    logic [1:0]  nsel;
    logic [3:0][6:0] grp;
    logic [3:0][7:0] seq;
    logic [EVT_BYTES-1:0][7:0] body;
    logic [LEN_W-1:0] blen;
    logic        emit;
    logic [7:0]  key_new;
    logic [7:0]  key_out;
    logic        mono_off;
    logic [2:0]  dlog;
    logic [13:0] bv;

    // Delta time as variable-length groups
    assign delta = abs_time - prev_time_reg;
    assign grp[0] = delta[6:0];
    assign grp[1] = delta[13:7];
    assign grp[2] = delta[20:14];
    assign grp[3] = delta[27:21];

    always_comb
    begin
        priority if (delta[27:21] != 7'd0)
            nsel = 2'd3;
        else if (delta[20:14] != 7'd0)
            nsel = 2'd2;
        else if (delta[13:7] != 7'd0)
            nsel = 2'd1;
        else
            nsel = 2'd0;
    end

    // Most significant group first, continuation bit on all but the last
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            seq[j] = {(2'(j) != nsel), grp[nsel - 2'(j)]};
        end
    end

    // Note key and helpers
    assign key_new  = data_a + ((channel == DRUM_CHAN) ? 8'd0 : transpose_reg);
    assign mono_off = monophonic_reg && (operation == OP_NOTE_OFF);
    assign key_out  = mono_off ? prev_key_reg : key_new;
    assign bv       = {~bend_amount[13], bend_amount[12:0]};

    always_comb
    begin
        dlog = 3'd0;
        for (int i = 1; i < 8; i++)
        begin
            if (data_b[i])
                dlog = 3'(i);
        end
    end

    // Status and data bytes
    always_comb
    begin
        body = '0;
        blen = '0;
        emit = 1'b1;
        unique case (operation)
            OP_NOTE_ON, OP_NOTE_OFF:
            begin
                body[0] = ((operation == OP_NOTE_ON) ? ST_NOTE_ON : ST_NOTE_OFF)
                          | {4'd0, channel};
                body[1] = key_out;
                body[2] = data_b;
                blen    = LEN_W'(3);
            end
            OP_CTRL:
            begin
                body[0] = ST_CTRL | {4'd0, channel};
                body[1] = {1'b0, data_a[6:0]};
                body[2] = data_b;
                blen    = LEN_W'(3);
            end
            OP_PROG:
            begin
                body[0] = ST_PROG | {4'd0, channel};
                body[1] = {1'b0, data_a[6:0]};
                blen    = LEN_W'(2);
            end
            OP_BEND:
            begin
                body[0] = ST_BEND | {4'd0, channel};
                body[1] = {1'b0, bv[6:0]};
                body[2] = {1'b0, bv[13:7]};
                blen    = LEN_W'(3);
            end
            OP_TEMPO:
            begin
                body[0] = ST_META;
                body[1] = META_TEMPO;
                body[2] = 8'h03;
                body[3] = tempo_us[23:16];
                body[4] = tempo_us[15:8];
                body[5] = tempo_us[7:0];
                blen    = LEN_W'(6);
            end
            OP_TIMESIG:
            begin
                body[0] = ST_META;
                body[1] = META_TSIG;
                body[2] = 8'h04;
                body[3] = data_a;
                body[4] = {5'd0, dlog};
                body[5] = data_c;
                body[6] = 8'h08;
                blen    = LEN_W'(7);
            end
            OP_EOT:
            begin
                body[0] = ST_META;
                body[1] = META_EOT;
                body[2] = 8'h00;
                blen    = LEN_W'(3);
            end
            OP_MASTVOL:
            begin
                body[0] = ST_SYSEX;
                body[1] = 8'h07;
                body[2] = 8'h7F;
                body[3] = 8'h7F;
                body[4] = 8'h04;
                body[5] = 8'h01;
                body[6] = 8'h00;
                body[7] = {1'b0, data_a[6:0]};
                body[8] = ST_EOX;
                blen    = LEN_W'(BODY_BYTES);
            end
            OP_GM_RESET:
            begin
                body[0] = ST_SYSEX;
                body[1] = 8'h05;
                body[2] = 8'h7E;
                body[3] = 8'h7F;
                body[4] = 8'h09;
                body[5] = 8'h01;
                body[6] = ST_EOX;
                blen    = LEN_W'(7);
            end
            default:
                emit = 1'b0;
        endcase
    end

    // Splice delta bytes in front of the body
    always_comb
    begin
        for (int k = 0; k < EVT_BYTES; k++)
        begin
            evt.bytes[k] = body[LEN_W'(k) - LEN_W'(nsel) - LEN_W'(1)];
        end
        for (int k = 0; k < 4; k++)
        begin
            if (2'(k) <= nsel)
                evt.bytes[k] = seq[k];
        end
        evt.len = emit ? (LEN_W'(nsel) + LEN_W'(1) + blen) : '0;
    end

    // Track state update
    always_comb
    begin
        monophonic_next = cfg_fire ? cfg_data : monophonic_reg;
        prev_time_next  = prev_time_reg;
        prev_key_next   = prev_key_reg;
        transpose_next  = transpose_reg;
        if (in_fire)
        begin
            priority if (operation == OP_TRANSPOSE)
            begin
                transpose_next = transpose_amount;
            end
            else if (operation == OP_TRACK_START)
            begin
                prev_time_next = '0;
                prev_key_next  = '0;
                transpose_next = '0;
            end
            else
            begin
                // unused codes leave the track state alone
                if (emit)
                begin
                    prev_time_next = abs_time;
                    if ((operation == OP_NOTE_ON || operation == OP_NOTE_OFF) && !mono_off)
                        prev_key_next = key_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monophonic_reg <= 1'b0;
            prev_time_reg  <= '0;
            prev_key_reg   <= '0;
            transpose_reg  <= '0;
        end
        else
        begin
            monophonic_reg <= monophonic_next;
            prev_time_reg  <= prev_time_next;
            prev_key_reg   <= prev_key_next;
            transpose_reg  <= transpose_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mtes_serializer.sv
`default_nettype none

module mtes_serializer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire mtes_pkg::evt_t evt,
    output logic               load_ok,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               last
);
    import mtes_pkg::*;

    logic [EVT_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [LEN_W-1:0]          cnt_reg, cnt_next;
    logic                      out_fire;

    assign out_fire  = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_byte  = bytes_reg[0];
    assign last      = (cnt_reg == LEN_W'(1));

    // Free now, or freed by the final beat of this cycle
    assign load_ok = !out_valid || (last && out_ready);

    // Shift one byte out per beat; a new event reloads the buffer
    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            bytes_next = evt.bytes;
            cnt_next   = evt.len;
        end
        else if (out_fire)
        begin
            bytes_next = bytes_reg >> 8;
            cnt_next   = cnt_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire

>>> hdl/midi_track_event_serializer_top.sv
// Standard MIDI File track event serializer.
// Input channel (in_valid/in_ready): one track event per beat. Output channel
// (out_valid/out_ready): the event's track bytes, one per beat, with last set
// on the final byte. Configuration channel (cfg_valid/cfg_ready): the
// monophonic bit; always ready, write only while the block is idle.
// The first byte of an event is on the output in the cycle after the
// event is accepted. An event of N bytes (3 to 13, delta included)
// occupies the output buffer until its last byte is taken; the next event is
// accepted in the same cycle its predecessor's last byte is taken, so the
// output streams one byte per cycle without gaps while the receiver is ready
// and events keep coming. Transpose, track start and unused codes emit nothing.
// Reset clears the output buffer, the previous time, key and transpose,
// and the monophonic bit. When the receiver stalls, the current byte holds
// and in_ready stays low until the last byte of the buffered event leaves.
`default_nettype none

module midi_track_event_serializer_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [3:0]    operation,
    input  wire logic [27:0]   abs_time,
    input  wire logic [3:0]    channel,
    input  wire logic [7:0]    data_a,
    input  wire logic [7:0]    data_b,
    input  wire logic [7:0]    data_c,
    input  wire logic [13:0]   bend_amount,
    input  wire logic [23:0]   tempo_us,
    input  wire logic [7:0]    transpose_amount,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               last
);
    import mtes_pkg::*;

    evt_t evt;
    logic in_fire;
    logic cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    // Event encoder and track state
    mtes_encoder u_enc (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_fire         (cfg_fire),
        .cfg_data         (cfg_data),
        .in_fire          (in_fire),
        .operation        (operation),
        .abs_time         (abs_time),
        .channel          (channel),
        .data_a           (data_a),
        .data_b           (data_b),
        .data_c           (data_c),
        .bend_amount      (bend_amount),
        .tempo_us         (tempo_us),
        .transpose_amount (transpose_amount),
        .evt              (evt)
    );

    // Byte output buffer
    mtes_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .evt       (evt),
        .load_ok   (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

`default_nettype wire

>>> hdl/mtes_checker.sv
`default_nettype none

module mtes_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [3:0]  operation,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  out_byte,
    input  wire logic        last
);
    import mtes_pkg::*;

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output beat changed while stalled");

    // Empty buffer always takes a new event
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output buffer");

    // Final beat taken with nothing loaded drains the output
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("output still valid after final beat");

    // A note event always produces bytes next cycle
    a_note_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == OP_NOTE_ON || operation == OP_NOTE_OFF)
        |=> out_valid && !last)
        else $error("note event produced no bytes");

    // Silent events leave an idle output idle
    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid &&
        (operation == OP_TRANSPOSE || operation == OP_TRACK_START || operation > OP_TRACK_START)
        |=> !out_valid)
        else $error("silent event produced bytes");

endmodule

bind midi_track_event_serializer_top mtes_checker u_mtes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
);

`default_nettype wire

>>> tb/midi_track_checker.sv
`timescale 1ns / 1ps

module midi_track_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [3:0]  operation,
    input  wire logic [27:0] abs_time,
    input  wire logic [3:0]  channel,
    input  wire logic [7:0]  data_a,
    input  wire logic [7:0]  data_b,
    input  wire logic [7:0]  data_c,
    input  wire logic [13:0] bend_amount,
    input  wire logic [23:0] tempo_us,
    input  wire logic [7:0]  transpose_amount,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  out_byte,
    input  wire logic        last,
    output int               fail_count,
    output int               pending_bytes
);
    import mtes_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } track_byte_t;

    // Bytes still owed by the block, oldest first
    track_byte_t track_bytes_q[$];

    // Bytes of the event being worked out
    logic [7:0] evt_seq[16];
    logic [3:0] evt_len;

    // Predicted track state
    logic [27:0] last_time;
    logic [7:0]  last_key;
    logic [7:0]  key_shift;
    logic        mono_mode;

    task automatic report_mismatch(input string what, input int expv, input int gotv);
        $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, expv, gotv);
        fail_count++;
    endtask

    task automatic append_byte(input logic [7:0] b);
        evt_seq[evt_len] = b;
        evt_len = evt_len + 4'd1;
    endtask

    // Work out the track bytes of one accepted event and queue them
    task automatic encode_track_event();
        logic [27:0] delta;
        logic [13:0] centered;
        logic [7:0]  denom;
        logic [7:0]  exponent;
        int          ngroups;

        if (operation == OP_TRANSPOSE) begin
            key_shift = transpose_amount;
            return;
        end
        if (operation == OP_TRACK_START) begin
            last_time = '0;
            key_shift = '0;
            last_key  = '0;
            return;
        end
        if (operation > OP_TRACK_START)
            return;

        evt_len = '0;

        // delta as variable-length quantity, wraps at 28 bits
        delta = abs_time - last_time;
        if (delta >= 28'd2097152)
            ngroups = 4;
        else if (delta >= 28'd16384)
            ngroups = 3;
        else if (delta >= 28'd128)
            ngroups = 2;
        else
            ngroups = 1;
        for (int g = ngroups - 1; g >= 0; g--)
            append_byte({(g > 0) ? 1'b1 : 1'b0, delta[7*g +: 7]});

        case (operation)
            OP_NOTE_ON, OP_NOTE_OFF:
            begin
                append_byte(((operation == OP_NOTE_ON) ? ST_NOTE_ON : ST_NOTE_OFF)
                            | {4'd0, channel});
                // mono note off repeats the stored key
                if (!(mono_mode && operation == OP_NOTE_OFF))
                    last_key = data_a + ((channel == DRUM_CHAN) ? 8'd0 : key_shift);
                append_byte(last_key);
                append_byte(data_b);
            end
            OP_CTRL:
            begin
                append_byte(ST_CTRL | {4'd0, channel});
                append_byte({1'b0, data_a[6:0]});
                append_byte(data_b);
            end
            OP_PROG:
            begin
                append_byte(ST_PROG | {4'd0, channel});
                append_byte({1'b0, data_a[6:0]});
            end
            OP_BEND:
            begin
                centered = bend_amount + 14'h2000;
                append_byte(ST_BEND | {4'd0, channel});
                append_byte({1'b0, centered[6:0]});
                append_byte({1'b0, centered[13:7]});
            end
            OP_TEMPO:
            begin
                append_byte(ST_META);
                append_byte(META_TEMPO);
                append_byte(8'h03);
                append_byte(tempo_us[23:16]);
                append_byte(tempo_us[15:8]);
                append_byte(tempo_us[7:0]);
            end
            OP_TIMESIG:
            begin
                // floor log2, zero denominator gives zero
                denom = data_b;
                exponent = '0;
                while (denom > 8'd1)
                begin
                    denom = denom >> 1;
                    exponent++;
                end
                append_byte(ST_META);
                append_byte(META_TSIG);
                append_byte(8'h04);
                append_byte(data_a);
                append_byte(exponent);
                append_byte(data_c);
                append_byte(8'h08);
            end
            OP_EOT:
            begin
                append_byte(ST_META);
                append_byte(META_EOT);
                append_byte(8'h00);
            end
            OP_MASTVOL:
            begin
                append_byte(ST_SYSEX);
                append_byte(8'h07);
                append_byte(8'h7F);
                append_byte(8'h7F);
                append_byte(8'h04);
                append_byte(8'h01);
                append_byte(8'h00);
                append_byte({1'b0, data_a[6:0]});
                append_byte(ST_EOX);
            end
            default:
            begin
                // GM reset
                append_byte(ST_SYSEX);
                append_byte(8'h05);
                append_byte(8'h7E);
                append_byte(8'h7F);
                append_byte(8'h09);
                append_byte(8'h01);
                append_byte(ST_EOX);
            end
        endcase
        last_time = abs_time;

        for (int k = 0; k < int'(evt_len); k++)
            track_bytes_q.insert(track_bytes_q.size(),
                                 '{value: evt_seq[k], is_last: (k == int'(evt_len) - 1)});
    endtask

    // Watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        track_byte_t want;
        if (!rst_n)
        begin
            last_time = '0;
            last_key = '0;
            key_shift = '0;
            mono_mode = 1'b0;
            evt_len = '0;
            fail_count = 0;
            pending_bytes = 0;
            track_bytes_q.delete();
        end
        else
        begin
            // result beat against oldest expectation
            if (out_valid && out_ready)
            begin
                if (track_bytes_q.size() == 0)
                    report_mismatch("unexpected byte", -1, out_byte);
                else
                begin
                    want = track_bytes_q.pop_front();
                    if (out_byte !== want.value)
                        report_mismatch("out_byte", want.value, out_byte);
                    if (last !== want.is_last)
                        report_mismatch("last", want.is_last, last);
                end
            end
            if (cfg_valid && cfg_ready)
                mono_mode = cfg_data;
            if (in_valid && in_ready)
                encode_track_event();
            pending_bytes = track_bytes_q.size();
        end
    end

endmodule

>>> tb/tb_midi_track_event_serializer_top.sv
`timescale 1ns / 1ps

module tb_midi_track_event_serializer_top;
    import mtes_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES = 20;
    localparam logic [3:0] OP_UNUSED_LO = 4'd12;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic [3:0]  op;
        logic [27:0] t;
        logic [3:0]  ch;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [13:0] bend;
        logic [23:0] tempo;
        logic [7:0]  tr;
    } track_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  operation = '0;
    logic [27:0] abs_time = '0;
    logic [3:0]  channel = '0;
    logic [7:0]  data_a = '0;
    logic [7:0]  data_b = '0;
    logic [7:0]  data_c = '0;
    logic [13:0] bend_amount = '0;
    logic [23:0] tempo_us = '0;
    logic [7:0]  transpose_amount = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        last;

    int fail_count;
    int pending_bytes;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int stall_cycles = 0;
    logic [27:0] track_time = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    midi_track_event_serializer_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .abs_time         (abs_time),
        .channel          (channel),
        .data_a           (data_a),
        .data_b           (data_b),
        .data_c           (data_c),
        .bend_amount      (bend_amount),
        .tempo_us         (tempo_us),
        .transpose_amount (transpose_amount),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_byte         (out_byte),
        .last             (last)
    );

    midi_track_checker i_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .abs_time         (abs_time),
        .channel          (channel),
        .data_a           (data_a),
        .data_b           (data_b),
        .data_c           (data_c),
        .bend_amount      (bend_amount),
        .tempo_us         (tempo_us),
        .transpose_amount (transpose_amount),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_byte         (out_byte),
        .last             (last),
        .fail_count       (fail_count),
        .pending_bytes    (pending_bytes)
    );

    // Receiver: random stalls, or a counted hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else
                out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic track_event_t random_payload(input logic [3:0] op, input logic [27:0] t);
        track_event_t ev;
        ev.op = op;
        ev.t = t;
        ev.ch = 4'($urandom_range(15));
        ev.a = 8'($urandom_range(255));
        ev.b = 8'($urandom_range(255));
        ev.c = 8'($urandom_range(255));
        ev.bend = 14'($urandom_range(16383));
        ev.tempo = 24'($urandom_range(24'hFFFFFF));
        ev.tr = 8'($urandom_range(255));
        return ev;
    endfunction

    // One beat on the event channel, with optional idle cycles ahead of it
    task automatic send_event(input track_event_t ev);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        operation = ev.op;
        abs_time = ev.t;
        channel = ev.ch;
        data_a = ev.a;
        data_b = ev.b;
        data_c = ev.c;
        bend_amount = ev.bend;
        tempo_us = ev.tempo;
        transpose_amount = ev.tr;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Stop sending and let every owed byte come out
    task automatic wait_drained(input int settle);
        in_valid = 1'b0;
        while (pending_bytes != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_mono(input logic value);
        cfg_data = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly forward-moving tracks with random content, some noise
    task automatic send_random_track(input int count);
        track_event_t ev;
        logic [3:0]   op;
        int           sent;
        int           pick;
        int           step;

        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            else if (pick < 12)
                op = OP_TRANSPOSE;
            else if (pick < 15)
                op = OP_TRACK_START;
            else if (pick < 55)
                op = 4'($urandom_range(OP_NOTE_OFF, OP_NOTE_ON));
            else
                op = 4'($urandom_range(OP_GM_RESET, OP_CTRL));

            // time step sized to hit every delta length, sometimes jump anywhere
            step = $urandom_range(99);
            if (step < 50)
                track_time += 28'($urandom_range(127));
            else if (step < 75)
                track_time += 28'($urandom_range(16383));
            else if (step < 88)
                track_time += 28'($urandom_range(2097151));
            else if (step < 96)
                track_time += 28'($urandom_range(28'hFFFFFFF));
            else
                track_time = 28'($urandom_range(28'hFFFFFFF));

            ev = random_payload(op, track_time);
            send_event(ev);
            if (op == OP_TRACK_START)
                track_time = '0;
            if (op < OP_UNUSED_LO)
                sent++;
        end
    endtask

    initial
    begin
        track_event_t ev;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 84;
        @(negedge clk);
        write_mono(1'b0);

        // Directed: delta lengths, field extremes, every operation
        ev = random_payload(OP_NOTE_ON, 28'd0);
        ev.ch = 4'd0; ev.a = 8'd0; ev.b = 8'd0;
        send_event(ev);
        ev = random_payload(OP_NOTE_ON, 28'd127);
        ev.ch = 4'd15; ev.a = 8'hFF; ev.b = 8'hFF;
        send_event(ev);
        ev = random_payload(OP_NOTE_OFF, 28'd255);
        ev.ch = 4'd15; ev.a = 8'hFF; ev.b = 8'd0;
        send_event(ev);
        ev = random_payload(OP_TRANSPOSE, 28'd0);
        ev.tr = 8'd5;
        send_event(ev);
        ev = random_payload(OP_NOTE_ON, 28'd16639);
        ev.ch = 4'd3; ev.a = 8'd60;
        send_event(ev);
        // drum channel is not transposed
        ev = random_payload(OP_NOTE_ON, 28'd2113791);
        ev.ch = DRUM_CHAN; ev.a = 8'd36;
        send_event(ev);
        // key wraps past 255
        ev = random_payload(OP_TRANSPOSE, 28'd0);
        ev.tr = 8'h80;
        send_event(ev);
        ev = random_payload(OP_NOTE_OFF, 28'd2113791);
        ev.ch = 4'd2; ev.a = 8'hFF;
        send_event(ev);
        ev = random_payload(OP_CTRL, 28'd2113792);
        ev.a = 8'hFF; ev.b = 8'hFF;
        send_event(ev);
        ev = random_payload(OP_PROG, 28'd2113800);
        ev.a = 8'hFF;
        send_event(ev);
        ev = random_payload(OP_BEND, 28'd2113800);
        ev.bend = 14'h2000;
        send_event(ev);
        ev = random_payload(OP_BEND, 28'd2113801);
        ev.bend = 14'h1FFF;
        send_event(ev);
        ev = random_payload(OP_TEMPO, 28'd2113900);
        ev.tempo = 24'hFFFFFF;
        send_event(ev);
        ev = random_payload(OP_TEMPO, 28'd2113900);
        ev.tempo = 24'h000000;
        send_event(ev);
        // zero denominator, largest denominator, denominator of one
        ev = random_payload(OP_TIMESIG, 28'd2113901);
        ev.a = 8'hFF; ev.b = 8'd0; ev.c = 8'hFF;
        send_event(ev);
        ev = random_payload(OP_TIMESIG, 28'd2113902);
        ev.a = 8'd0; ev.b = 8'hFF; ev.c = 8'd0;
        send_event(ev);
        ev = random_payload(OP_TIMESIG, 28'd2113903);
        ev.a = 8'd4; ev.b = 8'd1; ev.c = 8'd24;
        send_event(ev);
        ev = random_payload(OP_MASTVOL, 28'd2113904);
        ev.a = 8'hFF;
        send_event(ev);
        send_event(random_payload(OP_GM_RESET, 28'd2113904));
        send_event(random_payload(OP_UNUSED_HI, 28'd5));
        // delta wraps backward, then the largest delta
        send_event(random_payload(OP_EOT, 28'd0));
        send_event(random_payload(OP_CTRL, 28'hFFFFFFF));
        send_event(random_payload(OP_TRACK_START, 28'd0));
        ev = random_payload(OP_NOTE_ON, 28'd10);
        ev.ch = 4'd0;
        send_event(ev);
        track_time = 28'd10;

        // sender pause until all bytes are out
        wait_drained(0);
        send_random_track(45);
        wait_drained(SETTLE_CYCLES);

        // Monophonic phase, receiver held off to back up the input
        write_mono(1'b1);
        send_idle_pct = 84;
        recv_idle_pct = 29;
        hold_cycles = HOLD_OFF_CYCLES;
        ev = random_payload(OP_NOTE_ON, track_time);
        ev.ch = 4'd1; ev.a = 8'd70;
        send_event(ev);
        ev = random_payload(OP_NOTE_OFF, track_time + 28'd5);
        ev.ch = 4'd1; ev.a = 8'd12;
        send_event(ev);
        ev = random_payload(OP_NOTE_OFF, track_time + 28'd9);
        ev.ch = DRUM_CHAN;
        send_event(ev);
        track_time += 28'd9;
        send_random_track(45);
        wait_drained(SETTLE_CYCLES);

        // Back to default, full rate on both sides
        write_mono(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_track(45);

        wait_drained(END_CYCLES);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/mtes_pkg.sv
hdl/mtes_encoder.sv
hdl/mtes_serializer.sv
hdl/midi_track_event_serializer_top.sv
hdl/mtes_checker.sv
tb/midi_track_checker.sv
tb/tb_midi_track_event_serializer_top.sv
